// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared check helpers; they expand to nothing when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// check at every clock edge, muted while reset is low
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check at every clock edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

// ===== src/akcs_pkg.sv =====
// ---------------------------------------------------------------------------
// akcs_pkg
// types and constants shared by the key calibrate and scale unit
// ---------------------------------------------------------------------------
package akcs_pkg;

	// field widths
	localparam int VAL_W      = 12;
	localparam int CH_W       = 5;
	localparam int OP_W       = 2;
	localparam int MODE_W     = 2;
	localparam int SCALE_W    = 20;
	localparam int FRAC_W     = 8;
	localparam int PROD_W     = VAL_W + SCALE_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam int MASK_W     = 32;
	localparam int DIV_STEPS  = SCALE_W;

	// item opcodes
	typedef enum logic [OP_W-1:0] {
		OP_SAMPLE = 2'd0,
		OP_START  = 2'd1,
		OP_JOIN   = 2'd2,
		OP_STOP   = 2'd3
	} op_t;

	// calibration modes
	typedef enum logic [MODE_W-1:0] {
		MODE_NONE   = 2'd0,
		MODE_SINGLE = 2'd1,
		MODE_ALL    = 2'd2
	} mode_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOVER_MASK = 1'd1;

	// constants
	localparam logic [VAL_W-1:0]   FULL_SCALE     = 12'hFFF;
	localparam logic [VAL_W-1:0]   HALF_SCALE     = 12'd2047;
	localparam logic [VAL_W-1:0]   DEADZONE_RESET = 12'd128;
	localparam logic [SCALE_W-1:0] UNITY_Q8       = 20'd256;
	localparam logic [SCALE_W-1:0] RESET_SCALE    = 20'd264;
	localparam logic [SCALE_W-1:0] SCALE_NUM      = 20'(4095 << FRAC_W);

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic eval;
		logic prep;
		logic div_start;
		logic diff;
		logic mul;
		logic out_load;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_div;
		logic div_done;
	} dp_sts_t;

endpackage

// ===== src/analog_key_calibrate_scale_unit.sv =====
// ---------------------------------------------------------------------------
// analog_key_calibrate_scale_unit
// per-channel min/max calibration with deadzone and Q8 scaling of samples
// ---------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  in      | in_valid / in_stall   | opcode, channel, raw_value
//  out     | out_valid / out_stall | out_channel, scaled_value, calib_state
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  one item at a time: evaluate, prepare, difference, multiply, then load the
//  result register, and the next accept in the cycle after; a min/max change
//  that forces a scale recompute adds the 20-step restoring divider pass
//  a new item is accepted while the previous result still waits on out_stall
//  out_stall holds a finished item in its output stage until the result
//  register is free
//  asynchronous reset loads all channel state at once, no clearing pass
// ---------------------------------------------------------------------------
module analog_key_calibrate_scale_unit #(
	parameter int CHANNELS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [akcs_pkg::OP_W-1:0]         opcode,
	input  logic [akcs_pkg::CH_W-1:0]         channel,
	input  logic [akcs_pkg::VAL_W-1:0]        raw_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [akcs_pkg::CH_W-1:0]         out_channel,
	output logic [akcs_pkg::VAL_W-1:0]        scaled_value,
	output logic [akcs_pkg::MODE_W-1:0]       calib_state,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [akcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [akcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	akcs_pkg::dp_cmd_t cmd;
	akcs_pkg::dp_sts_t sts;

	// registers are always writable
	assign cfg_ready = 1'b1;

	akcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	akcs_datapath #(
		.CHANNELS (CHANNELS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.opcode       (opcode),
		.channel      (channel),
		.raw_value    (raw_value),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_channel  (out_channel),
		.scaled_value (scaled_value),
		.calib_state  (calib_state)
	);

endmodule

// ===== src/akcs_div.sv =====
// ---------------------------------------------------------------------------
// akcs_div
// restoring divider, one quotient bit per cycle: (4095 << 8) / divisor
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module akcs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [akcs_pkg::VAL_W-1:0]    divisor,
	output logic                          done,
	output logic [akcs_pkg::SCALE_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(akcs_pkg::DIV_STEPS);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(akcs_pkg::DIV_STEPS - 1);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [akcs_pkg::VAL_W-1:0]    rem_q;
	logic [akcs_pkg::VAL_W-1:0]    dvs_q;
	logic [akcs_pkg::SCALE_W-1:0]  quo_q;

	logic [akcs_pkg::VAL_W:0]      shifted;
	logic                          ge;
	logic [akcs_pkg::VAL_W-1:0]    rem_next;

	// one restoring step
	always_comb begin
		shifted  = {rem_q, quo_q[akcs_pkg::SCALE_W-1]};
		ge       = shifted >= {1'b0, dvs_q};
		rem_next = ge ? akcs_pkg::VAL_W'(shifted - {1'b0, dvs_q})
		              : shifted[akcs_pkg::VAL_W-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= akcs_pkg::SCALE_NUM;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[akcs_pkg::SCALE_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	`ASSERT_RST(a_start_idle, clk, arst_n, start |-> !busy_q, "divider started while busy")

endmodule

// ===== src/akcs_ctrl.sv =====
// ---------------------------------------------------------------------------
// akcs_ctrl
// item sequencer: load, evaluate, scale update, difference, multiply and result hand-off
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module akcs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output akcs_pkg::dp_cmd_t  cmd,
	input  akcs_pkg::dp_sts_t  sts
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_EVAL = 7'b0000010,
		S_PREP = 7'b0000100,
		S_DIV  = 7'b0001000,
		S_DIFF = 7'b0010000,
		S_MUL  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_EVAL;
			S_EVAL: state_d = S_PREP;
			S_PREP: state_d = sts.need_div ? S_DIV : S_DIFF;
			S_DIV:  if (sts.div_done) state_d = S_DIFF;
			S_DIFF: state_d = S_MUL;
			S_MUL:  state_d = S_OUT;
			S_OUT:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath commands
	always_comb begin
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.eval      = (state_q == S_EVAL);
		cmd.prep      = (state_q == S_PREP);
		cmd.div_start = (state_q == S_PREP) && sts.need_div;
		cmd.diff      = (state_q == S_DIFF);
		cmd.mul       = (state_q == S_MUL);
		cmd.out_load  = (state_q == S_OUT) && out_free;
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	`ASSERT_RST(a_out_from_out_state, clk, arst_n, $rose(out_valid_q) |-> $past(state_q) == S_OUT, "result raised outside output state")
	`ASSERT_RST(a_div_needs_done, clk, arst_n, (state_q == S_DIV) && !sts.div_done |=> (state_q == S_DIV), "left divide state early")
	`ASSERT_CLK(a_reset_clears_out, clk, !arst_n |-> !out_valid_q, "result valid during reset")

endmodule

// ===== src/akcs_datapath.sv =====
// ---------------------------------------------------------------------------
// akcs_datapath
// per-channel calibration state, scale recompute and sample scaling
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module akcs_datapath #(
	parameter int CHANNELS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  akcs_pkg::dp_cmd_t                 cmd,
	output akcs_pkg::dp_sts_t                 sts,
	input  logic [akcs_pkg::OP_W-1:0]         opcode,
	input  logic [akcs_pkg::CH_W-1:0]         channel,
	input  logic [akcs_pkg::VAL_W-1:0]        raw_value,
	input  logic                              cfg_we,
	input  logic [akcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [akcs_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic [akcs_pkg::CH_W-1:0]         out_channel,
	output logic [akcs_pkg::VAL_W-1:0]        scaled_value,
	output logic [akcs_pkg::MODE_W-1:0]       calib_state
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int VW    = akcs_pkg::VAL_W;
	localparam int SW    = akcs_pkg::SCALE_W;
	localparam int PW    = akcs_pkg::PROD_W;
	localparam int FW    = akcs_pkg::FRAC_W;

	// configuration and global state
	logic [VW-1:0]                     deadzone_q;
	logic [akcs_pkg::MASK_W-1:0]       hover_mask_q;
	akcs_pkg::mode_t                   mode_q;
	logic [akcs_pkg::CH_W-1:0]         calib_ch_q;

	// per-channel state
	logic [VW-1:0]  min_level_q [CHANNELS];
	logic [VW-1:0]  max_level_q [CHANNELS];
	logic           invert_q    [CHANNELS];
	logic [SW-1:0]  scale_arr_q [CHANNELS];

	// item and work registers
	akcs_pkg::op_t              op_q;
	logic [akcs_pkg::CH_W-1:0]  ch_q;
	logic [VW-1:0]              raw_q;
	logic [VW-1:0]              v_q;
	logic [VW-1:0]              lo_q;
	logic [VW-1:0]              hi_q;
	logic [SW-1:0]              scale_q;
	logic                       upd_q;
	logic                       hover_q;
	logic [VW:0]                eff_q;
	logic [VW-1:0]              diff_q;
	logic [PW-1:0]              prod_q;
	logic [akcs_pkg::CH_W-1:0]  out_channel_q;
	logic [VW-1:0]              scaled_q;
	logic [akcs_pkg::MODE_W-1:0] calib_state_q;

	// evaluate stage signals
	logic              ch_valid;
	logic              hover;
	logic [IDX_W-1:0]  idx;
	logic [VW-1:0]     v;
	logic              track_en;
	logic              raise;
	logic              lower;
	logic [VW-1:0]     lo_new;
	logic [VW-1:0]     hi_new;
	logic              upd;
	logic              start_en;
	logic              join_en;
	logic              restart_en;

	// prep stage signals
	logic [VW:0]       eff;
	logic              span_pos;
	logic [VW-1:0]     divisor;
	logic              unity_wr;

	// divider
	logic              div_done;
	logic [SW-1:0]     div_quot;

	// output stage signals
	logic [VW-1:0]     sat;
	logic [VW-1:0]     result;

	// channel decode, state read and min/max tracking
	always_comb begin
		ch_valid = int'(ch_q) < CHANNELS;
		hover    = ch_valid && hover_mask_q[ch_q];
		idx      = ch_valid ? ch_q[IDX_W-1:0] : '0;
		v        = (hover && invert_q[idx]) ? (akcs_pkg::FULL_SCALE - raw_q) : raw_q;
		track_en = cmd.eval && (op_q == akcs_pkg::OP_SAMPLE) && ch_valid &&
		           (((mode_q == akcs_pkg::MODE_ALL) && hover) ||
		            ((mode_q == akcs_pkg::MODE_SINGLE) && (calib_ch_q == ch_q)));
		raise    = v > max_level_q[idx];
		lower    = v < min_level_q[idx];
		hi_new   = (track_en && raise) ? v : max_level_q[idx];
		lo_new   = (track_en && !raise && lower) ? v : min_level_q[idx];
		upd      = track_en && (raise || lower);
		start_en = cmd.eval && (op_q == akcs_pkg::OP_START) && ch_valid;
		join_en  = cmd.eval && (op_q == akcs_pkg::OP_JOIN) && hover;
		restart_en = start_en || join_en;
	end

	// effective minimum and divisor for the scale recompute
	always_comb begin
		eff      = {1'b0, lo_q} + {1'b0, deadzone_q};
		span_pos = {1'b0, hi_q} > eff;
		divisor  = hi_q - eff[VW-1:0];
		unity_wr = cmd.prep && upd_q && !span_pos;
	end

	assign sts.need_div = upd_q && span_pos;
	assign sts.div_done = div_done;

	akcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q   <= akcs_pkg::DEADZONE_RESET;
			hover_mask_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				akcs_pkg::REG_DEADZONE:   deadzone_q   <= cfg_data[VW-1:0];
				akcs_pkg::REG_HOVER_MASK: hover_mask_q <= cfg_data[akcs_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// calibration mode and target channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= akcs_pkg::MODE_NONE;
			calib_ch_q <= '0;
		end else if (start_en) begin
			mode_q     <= akcs_pkg::MODE_SINGLE;
			calib_ch_q <= ch_q;
		end else if (join_en) begin
			mode_q <= akcs_pkg::MODE_ALL;
		end else if (cmd.eval && (op_q == akcs_pkg::OP_STOP)) begin
			mode_q <= akcs_pkg::MODE_NONE;
		end
	end

	// per-channel min, max, invert and scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				min_level_q[i] <= '0;
				max_level_q[i] <= akcs_pkg::FULL_SCALE;
				invert_q[i]    <= 1'b0;
				scale_arr_q[i] <= akcs_pkg::RESET_SCALE;
			end
		end else begin
			if (restart_en) begin
				min_level_q[idx] <= akcs_pkg::FULL_SCALE;
				max_level_q[idx] <= '0;
				invert_q[idx]    <= (raw_q >= akcs_pkg::HALF_SCALE);
			end else if (upd) begin
				min_level_q[idx] <= lo_new;
				max_level_q[idx] <= hi_new;
			end
			if (unity_wr) begin
				scale_arr_q[idx] <= akcs_pkg::UNITY_Q8;
			end else if (div_done) begin
				scale_arr_q[idx] <= div_quot;
			end
		end
	end

	// item capture and work registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= akcs_pkg::op_t'(opcode);
			ch_q  <= channel;
			raw_q <= raw_value;
		end
		if (cmd.eval) begin
			v_q     <= v;
			lo_q    <= lo_new;
			hi_q    <= hi_new;
			scale_q <= scale_arr_q[idx];
			upd_q   <= upd;
			hover_q <= hover;
		end
		if (cmd.prep) begin
			eff_q <= eff;
		end
		if (unity_wr) begin
			scale_q <= akcs_pkg::UNITY_Q8;
		end else if (div_done) begin
			scale_q <= div_quot;
		end
		if (cmd.diff) begin
			diff_q <= ({1'b0, v_q} > eff_q) ? (v_q - eff_q[VW-1:0]) : '0;
		end
		if (cmd.mul) begin
			prod_q <= PW'(diff_q) * PW'(scale_q);
		end
	end

	// saturate and pick the result
	always_comb begin
		sat = (|prod_q[PW-1:VW+FW]) ? akcs_pkg::FULL_SCALE : prod_q[VW+FW-1:FW];
		if (op_q == akcs_pkg::OP_SAMPLE) begin
			result = hover_q ? sat : raw_q;
		end else begin
			result = '0;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_channel_q <= ch_q;
			scaled_q      <= result;
			calib_state_q <= mode_q;
		end
	end

	assign out_channel  = out_channel_q;
	assign scaled_value = scaled_q;
	assign calib_state  = calib_state_q;

	`ASSERT_RST(a_div_only_on_update, clk, arst_n, cmd.div_start |-> upd_q, "scale divide without min/max change")
	`ASSERT_RST(a_scale_floor, clk, arst_n, cmd.mul |-> (scale_q >= akcs_pkg::UNITY_Q8), "scale below unity at multiply")

endmodule
